// ----- hdl/tsct_pkg.sv -----
package tsct_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ZREAD,
        ST_ZWAIT,
        ST_SCAN,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] zsel;
        logic [1:0] hsel;
        logic [1:0] lsel;
    } pair_t;

    localparam int NUM_PAIRS = 6;
    localparam int SUM_OUT_BITS = 62;
    localparam logic [1:0] SET_UNUSED = 2'd3;

    function automatic pair_t pair_lookup(input logic [2:0] p);
        pair_t r;
        case (p)
            3'd0: r = '{zsel: 2'd0, hsel: 2'd1, lsel: 2'd2};
            3'd1: r = '{zsel: 2'd0, hsel: 2'd2, lsel: 2'd1};
            3'd2: r = '{zsel: 2'd1, hsel: 2'd0, lsel: 2'd2};
            3'd3: r = '{zsel: 2'd1, hsel: 2'd2, lsel: 2'd0};
            3'd4: r = '{zsel: 2'd2, hsel: 2'd0, lsel: 2'd1};
            3'd5: r = '{zsel: 2'd2, hsel: 2'd1, lsel: 2'd0};
            default: r = '{zsel: 2'd0, hsel: 2'd1, lsel: 2'd2};
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/tsct_set_mem.sv -----
module tsct_set_mem #(
    parameter int DEPTH = 1024,
    parameter int AW = 10,
    parameter int DW = 30
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/three_set_closest_triple.sv -----
// Load: one request per cycle, each written straight into its set memory unless
// its set is full or its set id is 3 (unused). Search after the last request:
// brute force over six set orderings and over each element z of the first set;
// one read per set memory per cycle.
// Result follows the search; the next load is taken after it is delivered.
// aresetn (synchronous, active low) clears counts, flags and control;
// memory contents are not cleared and need no clearing pass.
module three_set_closest_triple
    import tsct_pkg::*;
#(
    parameter int SET_DEPTH = 1024,
    parameter int VALUE_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_set_id,
    input  logic [29:0] s_value,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [61:0] m_min_sum,
    output logic        m_found,
    output logic        m_overflow
);
    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int VB = VALUE_BITS;
    localparam int SQW = 2 * VB;
    localparam int SW = 2 * VB + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg [3];
    logic          ovf_reg;
    logic [2:0]    pair_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] k_reg;
    logic          pend_h_reg, pend_l_reg, pend_reg;
    logic [VB-1:0] z_reg, q_reg, w_reg;
    logic          has_q_reg, has_w_reg;
    logic [SQW-1:0] sq0_reg, sq1_reg, sq2_reg;
    logic [SW-1:0] best_reg;
    logic          best_valid_reg;

    logic [VB-1:0] rdata [3];
    logic [AW-1:0] raddr [3];
    pair_t         ps;
    logic [CW-1:0] nz, nh, nl, kmax;
    logic [VB-1:0] hd, ld;
    logic [VB-1:0] d_qw, d_qz, d_zw;
    logic [SW-1:0] sum;
    logic          acc;

    assign ps   = pair_lookup(pair_reg);
    assign nz   = cnt_reg[ps.zsel];
    assign nh   = cnt_reg[ps.hsel];
    assign nl   = cnt_reg[ps.lsel];
    assign kmax = (nh > nl) ? nh : nl;
    assign hd   = rdata[ps.hsel];
    assign ld   = rdata[ps.lsel];
    assign d_qw = q_reg - w_reg;
    assign d_qz = q_reg - z_reg;
    assign d_zw = z_reg - w_reg;
    assign sum  = SW'(sq0_reg) + SW'(sq1_reg) + SW'(sq2_reg);
    assign acc  = s_valid && s_ready;

    for (genvar g = 0; g < 3; g++) begin : g_mem
        logic we;
        assign we = acc && (s_set_id == 2'(g)) && (cnt_reg[g] < DEPTH_C);
        assign raddr[g] = (ps.zsel == 2'(g)) ? i_reg[AW-1:0] : k_reg[AW-1:0];
        tsct_set_mem #(.DEPTH(SET_DEPTH), .AW(AW), .DW(VB)) u_mem (
            .aclk  (aclk),
            .we    (we),
            .waddr (cnt_reg[g][AW-1:0]),
            .wdata (s_value[VB-1:0]),
            .raddr (raddr[g]),
            .rdata (rdata[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (acc && s_last) state_next = ST_ZREAD;
            ST_ZREAD: begin
                if (i_reg >= nz) begin
                    state_next = (pair_reg == 3'(NUM_PAIRS - 1)) ? ST_OUT : ST_ZREAD;
                end else begin
                    state_next = ST_ZWAIT;
                end
            end
            ST_ZWAIT: state_next = ST_SCAN;
            ST_SCAN:  if (k_reg >= kmax && !pend_reg) state_next = ST_MUL;
            ST_MUL:   state_next = (has_q_reg && has_w_reg) ? ST_SUM : ST_ZREAD;
            ST_SUM:   state_next = ST_ZREAD;
            ST_OUT:   if (m_ready) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_LOAD);
        m_valid    = (state_reg == ST_OUT);
        m_found    = best_valid_reg;
        m_overflow = ovf_reg;
        m_min_sum  = best_valid_reg ? SUM_OUT_BITS'(best_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            for (int j = 0; j < 3; j++) cnt_reg[j] <= '0;
            ovf_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            best_reg       <= '1;
            pair_reg       <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD: begin
                    if (acc && s_set_id != SET_UNUSED) begin
                        if (cnt_reg[s_set_id] < DEPTH_C) begin
                            cnt_reg[s_set_id] <= cnt_reg[s_set_id] + 1'b1;
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    pair_reg <= '0;
                    i_reg    <= '0;
                end
                ST_ZREAD: begin
                    if (i_reg >= nz) begin
                        i_reg <= '0;
                        if (pair_reg != 3'(NUM_PAIRS - 1)) pair_reg <= pair_reg + 1'b1;
                    end
                    k_reg     <= '0;
                    pend_reg  <= 1'b0;
                    has_q_reg <= 1'b0;
                    has_w_reg <= 1'b0;
                end
                ST_ZWAIT: z_reg <= rdata[ps.zsel];
                ST_SCAN: begin
                    if (k_reg < kmax) begin
                        pend_reg   <= 1'b1;
                        pend_h_reg <= (k_reg < nh);
                        pend_l_reg <= (k_reg < nl);
                        k_reg      <= k_reg + 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg) begin
                        if (pend_h_reg && hd >= z_reg && (!has_q_reg || hd < q_reg)) begin
                            q_reg     <= hd;
                            has_q_reg <= 1'b1;
                        end
                        if (pend_l_reg && ld <= z_reg && (!has_w_reg || ld > w_reg)) begin
                            w_reg     <= ld;
                            has_w_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    sq0_reg <= SQW'(d_qw) * SQW'(d_qw);
                    sq1_reg <= SQW'(d_qz) * SQW'(d_qz);
                    sq2_reg <= SQW'(d_zw) * SQW'(d_zw);
                    if (!(has_q_reg && has_w_reg)) i_reg <= i_reg + 1'b1;
                end
                ST_SUM: begin
                    if (!best_valid_reg || sum < best_reg) begin
                        best_reg       <= sum;
                        best_valid_reg <= 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        for (int j = 0; j < 3; j++) cnt_reg[j] <= '0;
                        ovf_reg        <= 1'b0;
                        best_valid_reg <= 1'b0;
                        best_reg       <= '1;
                    end
                end
                default: ;
            endcase
        end
    end

    // q at or above z and w at or below z hold once the scan finishes
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && has_q_reg && has_w_reg) |-> (q_reg >= z_reg && w_reg <= z_reg))
        else $error("candidate ordering broken");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("load and result overlap");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_min_sum == '0))
        else $error("min_sum nonzero without triple");
    a_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("read pending outside scan");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (cnt_reg[0] == '0 && !ovf_reg && !best_valid_reg))
        else $error("state not cleared after result");
endmodule

// ----- test/tb_top.sv -----
module tb_top
    import tsct_pkg::*;
;

    localparam int DEPTH = 1024;
    localparam int STALL_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 120;

    typedef struct {
        logic [61:0] min_sum;
        logic        found;
        logic        overflow;
    } triple_res_t;

    class triple_scoreboard;
        logic [29:0]  members[3][$];
        bit           overflow_seen;
        triple_res_t  pending_q[$];
        int           errors;

        function longint unsigned sq(logic [29:0] x, logic [29:0] y);
            longint unsigned d;
            d = (x >= y) ? longint'(x - y) : longint'(y - x);
            return d * d;
        endfunction

        function void search(int zi, int hi, int li, ref bit valid,
                             ref longint unsigned best);
            logic [29:0] z, q, w;
            bit hq, hw;
            longint unsigned s;
            for (int i = 0; i < members[zi].size(); i++) begin
                z = members[zi][i];
                hq = 0;
                hw = 0;
                q = 0;
                w = 0;
                for (int k = 0; k < members[hi].size(); k++)
                    if (members[hi][k] >= z && (!hq || members[hi][k] < q)) begin
                        q = members[hi][k];
                        hq = 1;
                    end
                for (int k = 0; k < members[li].size(); k++)
                    if (members[li][k] <= z && (!hw || members[li][k] > w)) begin
                        w = members[li][k];
                        hw = 1;
                    end
                if (hq && hw) begin
                    s = sq(q, w) + sq(q, z) + sq(z, w);
                    if (!valid || s < best) begin
                        best = s;
                        valid = 1;
                    end
                end
            end
        endfunction

        function void note(logic [1:0] set_id, logic [29:0] value, logic last);
            bit valid;
            longint unsigned best;
            triple_res_t r;
            if (set_id != SET_UNUSED) begin
                if (members[set_id].size() < DEPTH) members[set_id].push_back(value);
                else overflow_seen = 1;
            end
            if (!last) return;
            valid = 0;
            best = 0;
            search(0, 1, 2, valid, best);
            search(0, 2, 1, valid, best);
            search(1, 0, 2, valid, best);
            search(1, 2, 0, valid, best);
            search(2, 0, 1, valid, best);
            search(2, 1, 0, valid, best);
            r.min_sum = valid ? best[61:0] : '0;
            r.found = valid;
            r.overflow = overflow_seen;
            pending_q.push_back(r);
            for (int j = 0; j < 3; j++) members[j].delete();
            overflow_seen = 0;
        endfunction

        function void check(logic [61:0] min_sum, logic found, logic overflow);
            triple_res_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result sum=%0d", min_sum);
                return;
            end
            e = pending_q.pop_front();
            if (min_sum !== e.min_sum || found !== e.found || overflow !== e.overflow) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp sum=%0d found=%0d ovf=%0d",
                              " got sum=%0d found=%0d ovf=%0d"},
                             e.min_sum, e.found, e.overflow, min_sum, found, overflow);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_set_id = 0;
    logic [29:0] s_value = 0;
    logic        s_last = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [61:0] m_min_sum;
    logic        m_found;
    logic        m_overflow;

    triple_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_req = 0;
    int  stall_cnt = 0;

    three_set_closest_triple i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_set_id(s_set_id), .s_value(s_value), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_min_sum(m_min_sum), .m_found(m_found), .m_overflow(m_overflow)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    task automatic send(logic [1:0] set_id, logic [29:0] value, logic last);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_set_id <= set_id;
        s_value <= value;
        s_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note(set_id, value, last);
    endtask

    task automatic random_load(int n, bit narrow);
        logic [1:0]  sid;
        logic [29:0] v;
        for (int i = 0; i < n; i++) begin
            sid = ($urandom_range(9) == 0) ? SET_UNUSED : 2'($urandom_range(2));
            v = narrow ? 30'($urandom_range(20)) : 30'($urandom);
            send(sid, v, i == n - 1);
        end
    endtask

    // receiver and watchdog
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("[three_set_closest_triple] ERROR");
                $finish;
            end
            if (m_valid && m_ready) sb.check(m_min_sum, m_found, m_overflow);
            if (hold_req && hold == 0) begin
                hold = 3000;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin
        int sent;
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_idle = 24;
        recv_idle = 85;

        // extremes and corner cases
        send(0, 30'h0, 0);
        send(1, 30'h3fffffff, 0);
        send(2, 30'h1fffffff, 1);
        send(0, 30'd5, 0);
        send(1, 30'd6, 1);
        send(0, 30'd1, 0);
        send(1, 30'd2, 0);
        send(2, 30'd3, 0);
        send(SET_UNUSED, 30'h2aaaaaaa, 1);
        send(SET_UNUSED, 30'h15555555, 1);
        send(0, 30'd7, 0);
        send(1, 30'd7, 0);
        send(2, 30'd7, 1);
        send(2, 30'h3fffffff, 0);
        send(0, 30'h3ffffffe, 0);
        send(1, 30'h0, 0);
        send(1, 30'h3fffffff, 1);

        // overflow of one set
        for (int i = 0; i < DEPTH + 1; i++)
            send(0, (i % 2) ? 30'($urandom) : 30'($urandom_range(50)), 0);
        for (int i = 0; i < 3; i++) send(1, 30'($urandom_range(50)), 0);
        for (int i = 0; i < 2; i++) send(2, 30'($urandom_range(50)), 0);
        send(2, 30'($urandom), 1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS * 2 / 3) begin
                if (send_idle != 0) hold_req = 1;
                send_idle = 0;
                recv_idle = 0;
            end else if (sent >= RANDOM_ITEMS / 3) begin
                send_idle = 85;
                recv_idle = 24;
            end
            n = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            random_load(n, $urandom_range(1));
            sent += n;
        end
        s_valid <= 0;

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) $display("[three_set_closest_triple] OK");
        else $display("[three_set_closest_triple] ERROR");
        $finish;
    end
endmodule
